/* sv/card_whitelist_lock_controller_defines.svh */
// assertion macros shared by the lock controller rtl
`ifndef CARD_WHITELIST_LOCK_CONTROLLER_DEFINES_SVH
`define CARD_WHITELIST_LOCK_CONTROLLER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CWL_ASSERT_IMP(label, ant, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CWL_ASSERT_NXT(label, ant, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error(msg);

`endif

/* sv/cwl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cwl_pkg;

  // default configuration
  localparam int unsigned SLOT_COUNT_DEF = 64;
  localparam int unsigned UID_BYTES_DEF  = 7;

  // fixed field widths
  localparam int unsigned REQ_W      = 3;
  localparam int unsigned UID_LO_W   = 56;
  localparam int unsigned UID_HI_W   = 24;
  localparam int unsigned ULEN_W     = 4;
  localparam int unsigned SLOT_NUM_W = 8;
  localparam int unsigned STATUS_W   = 4;
  localparam int unsigned HIT_W      = 6;
  localparam int unsigned MODE_W     = 2;

  // longest uid the read buffer holds
  localparam logic [ULEN_W-1:0] READ_BUF_BYTES = 4'd10;
  // bytes held in the low uid word
  localparam logic [ULEN_W-1:0] LO_BYTES    = 4'd7;

  typedef enum logic [REQ_W-1:0] {
    REQ_CARD     = 3'd0,
    REQ_PROG     = 3'd1,
    REQ_ADD      = 3'd2,
    REQ_DEL      = 3'd3,
    REQ_CLEAR    = 3'd4,
    REQ_DEL_SLOT = 3'd5
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_IGNORED   = 4'd0,
    ST_GRANTED   = 4'd1,
    ST_DENIED    = 4'd2,
    ST_PROG      = 4'd3,
    ST_IDLE      = 4'd4,
    ST_ARMED_ADD = 4'd5,
    ST_ARMED_DEL = 4'd6,
    ST_EXISTS    = 4'd7,
    ST_FULL      = 4'd8,
    ST_STORED    = 4'd9,
    ST_NOT_FOUND = 4'd10,
    ST_DELETED   = 4'd11,
    ST_CLEARED   = 4'd12,
    ST_BAD_INDEX = 4'd13,
    ST_REPEAT    = 4'd14,
    ST_TOO_LONG  = 4'd15
  } status_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE = 2'd0,
    MODE_PROG = 2'd1,
    MODE_ADD  = 2'd2,
    MODE_DEL  = 2'd3
  } mode_e;

  // status flags from the table walker
  typedef struct packed {
    logic done;
    logic found;
    logic free_found;
  } scan_flags_t;

  // mask that keeps the low n bytes of a 64-bit word
  function automatic logic [63:0] byte_mask(input logic [ULEN_W-1:0] n);
    logic [63:0] m;
    m = (64'd1 << {n, 3'b000}) - 64'd1;
    if (n >= 4'd8) begin
      m = '1;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* sv/cwl_if.sv */
`timescale 1ns / 1ps
`default_nettype none

// request channel: one lock event per item
interface cwl_req_if;
  import cwl_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [REQ_W-1:0]      req_type;
  logic [UID_LO_W-1:0]   uid_low;
  logic [UID_HI_W-1:0]   uid_high;
  logic [ULEN_W-1:0]     uid_length;
  logic [SLOT_NUM_W-1:0] slot_number;

  modport source (
    output valid, req_type, uid_low, uid_high, uid_length, slot_number,
    input  ready
  );
  modport sink (
    input  valid, req_type, uid_low, uid_high, uid_length, slot_number,
    output ready
  );
endinterface

// response channel: one result per event
interface cwl_rsp_if;
  import cwl_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HIT_W-1:0]    slot_hit;
  logic [MODE_W-1:0]   mode_now;
  logic                door_open;

  modport source (
    output valid, status, slot_hit, mode_now, door_open,
    input  ready
  );
  modport sink (
    input  valid, status, slot_hit, mode_now, door_open,
    output ready
  );
endinterface

`default_nettype wire

/* sv/cwl_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module cwl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]                        wr_data_i,
  input  wire logic                                    rd_en_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]                        rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* sv/cwl_scan.sv */
`timescale 1ns / 1ps
`default_nettype none

module cwl_scan #(
  parameter int unsigned SLOT_COUNT = cwl_pkg::SLOT_COUNT_DEF,
  parameter int unsigned ENTRY_W    = 10,
  localparam int unsigned IDX_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [ENTRY_W-1:0]    key_i,
  input  wire logic [SLOT_COUNT-1:0] valid_i,
  output logic                       rd_en_o,
  output logic      [IDX_W-1:0]      rd_addr_o,
  input  wire logic [ENTRY_W-1:0]    rd_data_i,
  output cwl_pkg::scan_flags_t       flags_o,
  output logic      [IDX_W-1:0]      match_idx_o,
  output logic      [IDX_W-1:0]      free_idx_o
);
  import cwl_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  logic             issue_q, issue_d;
  logic [IDX_W-1:0] addr_q, addr_d;
  logic             cmp_q, cmp_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             done_q, done_d;
  logic             found_q, found_d;
  logic             free_found_q, free_found_d;
  logic [IDX_W-1:0] match_q, match_d;
  logic [IDX_W-1:0] free_q, free_d;
  logic             slot_live;

  assign slot_live = valid_i[cmp_idx_q];

  // walk the table one entry a cycle through the shared comparator
  always_comb begin
    issue_d      = issue_q;
    addr_d       = addr_q;
    cmp_d        = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    done_d       = done_q;
    found_d      = found_q;
    free_found_d = free_found_q;
    match_d      = match_q;
    free_d       = free_q;

    if (start_i) begin
      issue_d      = 1'b1;
      addr_d       = '0;
      done_d       = 1'b0;
      found_d      = 1'b0;
      free_found_d = 1'b0;
    end else begin
      // read issue
      if (issue_q) begin
        cmp_d     = 1'b1;
        cmp_idx_d = addr_q;
        if (addr_q == LAST_IDX) begin
          issue_d = 1'b0;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      // compare against the entry read last cycle
      if (cmp_q) begin
        if (!slot_live && !free_found_q) begin
          free_found_d = 1'b1;
          free_d       = cmp_idx_q;
        end
        if (slot_live && (rd_data_i == key_i)) begin
          found_d = 1'b1;
          match_d = cmp_idx_q;
          done_d  = 1'b1;
          issue_d = 1'b0;
          cmp_d   = 1'b0;
        end else if (cmp_idx_q == LAST_IDX) begin
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q      <= 1'b0;
      cmp_q        <= 1'b0;
      done_q       <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      issue_q      <= issue_d;
      cmp_q        <= cmp_d;
      done_q       <= done_d;
      found_q      <= found_d;
      free_found_q <= free_found_d;
    end
  end

  // indexes need no reset
  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    cmp_idx_q <= cmp_idx_d;
    match_q   <= match_d;
    free_q    <= free_d;
  end

  assign rd_en_o            = issue_q;
  assign rd_addr_o          = addr_q;
  assign flags_o.done       = done_q;
  assign flags_o.found      = found_q;
  assign flags_o.free_found = free_found_q;
  assign match_idx_o        = match_q;
  assign free_idx_o         = free_q;

endmodule

`default_nettype wire

/* sv/card_whitelist_lock_controller.sv */
// Card whitelist lock controller. Each request item is one event (card read, program
// press, add or delete press, clear all, delete slot) and yields exactly one response
// item with status, slot, mode after the event and the door-open strobe. Events that
// need no table lookup are answered from the decode state; a card read that reaches
// the table waits for the walk over the slot memory, one entry per cycle through its
// single read port and one comparator, stopping early on a match. A new item is
// accepted in the cycle after the previous response is loaded, while that response
// may still wait on the output register. Slot occupancy lives in flip-flops that
// reset clears at once, so no clearing pass follows reset and clear all takes effect
// when its response is loaded.
`timescale 1ns / 1ps
`default_nettype none
`include "card_whitelist_lock_controller_defines.svh"

module card_whitelist_lock_controller #(
  parameter int unsigned SLOT_COUNT = cwl_pkg::SLOT_COUNT_DEF,
  parameter int unsigned UID_BYTES  = cwl_pkg::UID_BYTES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cwl_req_if.sink   req_i,
  cwl_rsp_if.source rsp_o
);
  import cwl_pkg::*;

  localparam int unsigned IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned LEN_W   = $clog2(UID_BYTES + 1);
  localparam int unsigned KEY_W   = 8 * UID_BYTES;
  localparam int unsigned ENTRY_W = LEN_W + KEY_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DECODE = 3'b010,
    S_SCAN   = 3'b100
  } state_e;

  state_e                state_q, state_d;
  mode_e                 mode_q, mode_d;
  logic [SLOT_COUNT-1:0] valid_q, valid_d;
  logic [UID_LO_W-1:0]   last_lo_q, last_lo_d;
  logic [UID_HI_W-1:0]   last_hi_q, last_hi_d;
  logic [ULEN_W-1:0]     last_len_q, last_len_d;

  // captured event
  logic [REQ_W-1:0]      req_q;
  logic [UID_LO_W-1:0]   lo_q;
  logic [UID_HI_W-1:0]   hi_q;
  logic [ULEN_W-1:0]     n_q;
  logic [SLOT_NUM_W-1:0] slot_q;

  // response register
  logic                  rsp_valid_q, rsp_valid_d;
  status_e               status_q, status_d;
  logic [HIT_W-1:0]      hit_q, hit_d;
  mode_e                 mode_out_q, mode_out_d;
  logic                  door_q, door_d;

  logic                  in_acc;
  logic                  can_emit;
  logic                  emit;
  logic                  scan_start;
  logic                  ram_we;
  logic [ULEN_W-1:0]     nl, nh;
  logic [63:0]           mask_lo, mask_hi, mask_key, key64;
  logic [UID_LO_W-1:0]   mlo;
  logic [UID_HI_W-1:0]   mhi;
  logic                  same_card;
  logic                  too_long;
  logic                  card_scan;
  logic [ENTRY_W-1:0]    key_entry;
  logic [ENTRY_W-1:0]    rd_data;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  scan_flags_t           scan_flags;
  logic [IDX_W-1:0]      match_idx;
  logic [IDX_W-1:0]      free_idx;
  logic                  slot_ok;
  logic [IDX_W-1:0]      slot_idx;

  assign in_acc      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign can_emit    = !rsp_valid_q || rsp_o.ready;

  // uid masking and repeat detection
  assign nl        = (n_q > LO_BYTES) ? LO_BYTES : n_q;
  assign nh        = (n_q > LO_BYTES) ? (n_q - LO_BYTES) : '0;
  assign mask_lo   = byte_mask(nl);
  assign mask_hi   = byte_mask(nh);
  assign mask_key  = byte_mask(n_q);
  assign mlo       = lo_q & mask_lo[UID_LO_W-1:0];
  assign mhi       = hi_q & mask_hi[UID_HI_W-1:0];
  assign key64     = {hi_q[7:0], lo_q} & mask_key;
  assign key_entry = {n_q[LEN_W-1:0], key64[KEY_W-1:0]};
  assign same_card = (n_q == last_len_q) && (mlo == last_lo_q) && (mhi == last_hi_q);
  assign too_long  = (n_q > ULEN_W'(UID_BYTES));
  assign card_scan = (n_q != '0) && (mode_q != MODE_PROG) && !same_card && !too_long;
  assign slot_ok   = ({1'b0, slot_q} < (SLOT_NUM_W + 1)'(SLOT_COUNT));
  assign slot_idx  = slot_q[IDX_W-1:0];

  // event sequencer
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    valid_d     = valid_q;
    last_lo_d   = last_lo_q;
    last_hi_d   = last_hi_q;
    last_len_d  = last_len_q;
    rsp_valid_d = rsp_valid_q;
    status_d    = status_q;
    hit_d       = hit_q;
    mode_out_d  = mode_out_q;
    door_d      = door_q;
    scan_start  = 1'b0;
    ram_we      = 1'b0;
    emit        = 1'b0;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        if ((req_e'(req_q) == REQ_CARD) && card_scan) begin
          scan_start = 1'b1;
          state_d    = S_SCAN;
        end else if (can_emit) begin
          emit     = 1'b1;
          status_d = ST_IGNORED;
          hit_d    = '0;
          door_d   = 1'b0;
          unique case (req_e'(req_q))
            REQ_CARD: begin
              if ((n_q != '0) && (mode_q != MODE_PROG)) begin
                if (same_card) begin
                  status_d = ST_REPEAT;
                end else begin
                  // too long: record as last card, leave wait modes
                  status_d   = ST_TOO_LONG;
                  last_lo_d  = mlo;
                  last_hi_d  = mhi;
                  last_len_d = n_q;
                  if (mode_q != MODE_IDLE) begin
                    mode_d = MODE_PROG;
                  end
                end
              end
            end
            REQ_PROG: begin
              if (mode_q == MODE_IDLE) begin
                mode_d   = MODE_PROG;
                status_d = ST_PROG;
              end else begin
                mode_d     = MODE_IDLE;
                status_d   = ST_IDLE;
                last_lo_d  = '0;
                last_hi_d  = '0;
                last_len_d = '0;
              end
            end
            REQ_ADD: begin
              if (mode_q == MODE_PROG) begin
                mode_d   = MODE_ADD;
                status_d = ST_ARMED_ADD;
              end
            end
            REQ_DEL: begin
              if (mode_q == MODE_PROG) begin
                mode_d   = MODE_DEL;
                status_d = ST_ARMED_DEL;
              end
            end
            REQ_CLEAR: begin
              valid_d  = '0;
              status_d = ST_CLEARED;
            end
            REQ_DEL_SLOT: begin
              if (slot_ok) begin
                valid_d[slot_idx] = 1'b0;
                status_d          = ST_DELETED;
                hit_d             = HIT_W'(slot_q);
              end else begin
                status_d = ST_BAD_INDEX;
              end
            end
            default: begin
              status_d = ST_IGNORED;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (scan_flags.done && can_emit) begin
          emit     = 1'b1;
          hit_d    = '0;
          door_d   = 1'b0;
          status_d = ST_IGNORED;
          unique case (mode_q)
            MODE_IDLE: begin
              if (scan_flags.found) begin
                status_d = ST_GRANTED;
                door_d   = 1'b1;
                hit_d    = HIT_W'(match_idx);
              end else begin
                status_d = ST_DENIED;
              end
            end
            MODE_ADD: begin
              if (scan_flags.found) begin
                status_d = ST_EXISTS;
                hit_d    = HIT_W'(match_idx);
              end else if (scan_flags.free_found) begin
                ram_we            = 1'b1;
                valid_d[free_idx] = 1'b1;
                status_d          = ST_STORED;
                hit_d             = HIT_W'(free_idx);
              end else begin
                status_d = ST_FULL;
              end
            end
            MODE_DEL: begin
              if (scan_flags.found) begin
                valid_d[match_idx] = 1'b0;
                status_d           = ST_DELETED;
                hit_d              = HIT_W'(match_idx);
              end else begin
                status_d = ST_NOT_FOUND;
              end
            end
            default: begin
              status_d = ST_IGNORED;
            end
          endcase
          if (mode_q != MODE_IDLE) begin
            mode_d = MODE_PROG;
          end
          last_lo_d  = mlo;
          last_hi_d  = mhi;
          last_len_d = n_q;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // load the response register
    if (emit) begin
      rsp_valid_d = 1'b1;
      mode_out_d  = mode_d;
      state_d     = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_IDLE;
      valid_q     <= '0;
      last_lo_q   <= '0;
      last_hi_q   <= '0;
      last_len_q  <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      valid_q     <= valid_d;
      last_lo_q   <= last_lo_d;
      last_hi_q   <= last_hi_d;
      last_len_q  <= last_len_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q  <= req_i.req_type;
      lo_q   <= req_i.uid_low;
      hi_q   <= req_i.uid_high;
      n_q    <= (req_i.uid_length > READ_BUF_BYTES) ? READ_BUF_BYTES : req_i.uid_length;
      slot_q <= req_i.slot_number;
    end
    status_q   <= status_d;
    hit_q      <= hit_d;
    mode_out_q <= mode_out_d;
    door_q     <= door_d;
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.slot_hit  = hit_q;
  assign rsp_o.mode_now  = mode_out_q;
  assign rsp_o.door_open = door_q;

  // slot memory: stored length and uid per slot
  cwl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .wr_addr_i (free_idx),
    .wr_data_i (key_entry),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // table walker
  cwl_scan #(
    .SLOT_COUNT (SLOT_COUNT),
    .ENTRY_W    (ENTRY_W)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (scan_start),
    .key_i       (key_entry),
    .valid_i     (valid_q),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .flags_o     (scan_flags),
    .match_idx_o (match_idx),
    .free_idx_o  (free_idx)
  );

  // checks
  `CWL_ASSERT_IMP(a_door_granted, rsp_o.valid && rsp_o.door_open, rsp_o.status == ST_GRANTED, "door open without grant")
  `CWL_ASSERT_IMP(a_match_live, (state_q == S_SCAN) && scan_flags.done && scan_flags.found, valid_q[match_idx], "match on a free slot")
  `CWL_ASSERT_IMP(a_store_free, ram_we, !valid_q[free_idx], "store over a live slot")
  `CWL_ASSERT_NXT(a_clear_all, emit && (req_e'(req_q) == REQ_CLEAR) && (state_q == S_DECODE), valid_q == '0, "clear all left live slots")

endmodule

`default_nettype wire
